### rtl/core/assert_macros.svh
// Assertion macros shared by the key compare checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CKC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key compare assertion failed");

// Next-cycle implication, off while reset is high.
`define CKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key compare assertion failed");

// Next-cycle implication that also covers reset itself.
`define CKC_ASSERT_NEXT_RAW(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("key compare assertion failed");

`endif

### rtl/core/ckc_pkg.sv
// Types, codes and helpers for the composite key compare unit.
package ckc_pkg;

   // field kind codes, two bits per field in the kinds register
   typedef enum logic [1:0] {
      KIND_INT = 2'd0,
      KIND_STR = 2'd1,
      KIND_VEC = 2'd2,
      KIND_BAD = 2'd3
   } kind_type;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_FIELD_COUNT    = 2'd0,
      CSR_FIELD_KINDS    = 2'd1,
      CSR_FIELD_WIDTHS   = 2'd2,
      CSR_VECTOR_LENGTHS = 2'd3
   } csr_index_type;

   // outcome of the field walk
   typedef enum logic [1:0] {
      WALK_GO  = 2'd0,
      WALK_END = 2'd1,
      WALK_BAD = 2'd2
   } walk_type;

   // one field as described by the registers
   typedef struct packed {
      kind_type   kind;
      logic [7:0] width;
      logic [7:0] count;
   } field_desc_type;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // fields that have bits in the layout registers
   localparam int HW_FIELDS = 4;

   // order codes, two-bit signed
   localparam logic [1:0] ORDER_EQUAL   = 2'b00;
   localparam logic [1:0] ORDER_GREATER = 2'b01;
   localparam logic [1:0] ORDER_LESS    = 2'b11;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // register defaults: one 4-byte integer field
   localparam logic [2:0]  CFG_COUNT_RESET   = 3'd1;
   localparam logic [7:0]  CFG_KINDS_RESET   = 8'h00;
   localparam logic [31:0] CFG_WIDTHS_RESET  = 32'h0404_0404;
   localparam logic [31:0] CFG_LENGTHS_RESET = 32'h0000_0000;

   localparam logic [7:0] FOLD_LO     = 8'h41;
   localparam logic [7:0] FOLD_HI     = 8'h5A;
   localparam logic [7:0] FOLD_OFFSET = 8'h20;

   // A-Z to lower case, everything else untouched
   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      return (c >= FOLD_LO && c <= FOLD_HI) ? c + FOLD_OFFSET : c;
   endfunction

endpackage

### rtl/core/composite_key_compare_unit.sv
// Top level of the composite key compare unit: byte-pair walk over a multi-field key.
//
//   channel | dir | ports                       | word
//   --------+-----+-----------------------------+----------------------------------
//   req     | in  | req_tvalid/tready/tdata     | byte_a [7:0], byte_b [15:8]
//   rsp     | out | rsp_tvalid/tready/tdata/tuser | order [1:0] in tdata, status in tuser
//   csr     | in  | csr_we/csr_addr/csr_wdata   | register write, no read-back
//
// One word per cycle sustained while rsp is not stalled. A word is held in the input register,
// then the field walk, byte fold/compare and position update run combinationally into
// the walk state and the result register.
// Synchronous reset clears the walk, empties both registers and loads the default
// layout (one 4-byte integer field).
// A stalled rsp holds its word; req_tready drops only when the input register is
// full and its word cannot move on.
module composite_key_compare_unit
   import ckc_pkg::*;
#(
   parameter int MAX_FIELDS      = 4,
   parameter int MAX_FIELD_BYTES = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   // csr write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // byte pair in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // byte_a [7:0], byte_b [15:8]
   // compare result out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // order [1:0], zero [7:2]
   output logic                  rsp_tuser    // status [0]
);

   // field_pos also has to hold "past the last field"
   localparam int POS_W  = $clog2(MAX_FIELDS + 1);
   localparam int BPOS_W = $clog2(MAX_FIELD_BYTES + 1);
   localparam logic [3:0] MAX_FIELDS_4 = 4'(MAX_FIELDS);
   localparam logic [7:0] STR_CAP      = 8'(MAX_FIELD_BYTES);

   typedef struct packed {
      walk_type         how;
      logic [POS_W-1:0] pos;
   } walk_res_type;

   // layout registers
   logic [2:0]  cfg_count_ff,   cfg_count_in;
   logic [7:0]  cfg_kinds_ff,   cfg_kinds_in;
   logic [31:0] cfg_widths_ff,  cfg_widths_in;
   logic [31:0] cfg_lengths_ff, cfg_lengths_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_a_ff, in_a_in;
   logic [7:0]  in_b_ff, in_b_in;

   // walk state
   logic [POS_W-1:0]  field_pos_ff,     field_pos_in;
   logic [7:0]        element_pos_ff,   element_pos_in;
   logic [BPOS_W-1:0] byte_pos_ff,      byte_pos_in;
   logic [23:0]       gather_a_ff,      gather_a_in;  // bytes 0..2; byte 3 compares directly
   logic [23:0]       gather_b_ff,      gather_b_in;
   logic              decided_ff,       decided_in;
   logic [1:0]        decided_order_ff, decided_order_in;
   logic              string_ended_ff,  string_ended_in;

   // result register
   logic        rsp_valid_ff,  rsp_valid_in;
   logic [1:0]  rsp_order_ff,  rsp_order_in;
   logic        rsp_status_ff, rsp_status_in;

   field_desc_type          desc [MAX_FIELDS];
   logic [MAX_FIELDS-1:0]   skip_vec;
   logic [MAX_FIELDS-1:0]   bad_vec;
   logic [3:0]              used_4;
   logic [POS_W-1:0]        used_fields;

   logic                    advance;
   walk_res_type            walk1, walk2;
   logic                    moved1, moved2;
   field_desc_type          cur;
   logic [7:0]              st_elem;
   logic [BPOS_W-1:0]       st_bpos;
   logic [23:0]             st_ga, st_gb;
   logic                    st_str;
   logic [7:0]              fold_a, fold_b;
   logic [BPOS_W:0]         nb;
   logic                    insert;
   logic [31:0]             full_a, full_b;
   logic                    int_lt, int_eq;
   logic [7:0]              str_width;
   logic [8:0]              elem_next;
   logic [7:0]              elem_limit;
   logic                    t_decided;
   logic [1:0]              t_order;
   logic                    t_str;
   logic [7:0]              t_elem;
   logic [BPOS_W-1:0]       t_bpos;
   logic [23:0]             t_ga, t_gb;
   logic                    field_done;
   logic [POS_W-1:0]        pos_t;
   logic                    res_fire;

   // first field at or after start that holds bytes
   function automatic walk_res_type walk_from(
      input logic [POS_W-1:0]      start,
      input logic [MAX_FIELDS-1:0] skip,
      input logic [MAX_FIELDS-1:0] bad,
      input logic [POS_W-1:0]      used
   );
      walk_res_type r;
      r.how = WALK_END;
      r.pos = start;
      for (int j = MAX_FIELDS - 1; j >= 0; j--) begin
         if (POS_W'(j) >= start && POS_W'(j) < used && !skip[j]) begin
            r.pos = POS_W'(j);
            r.how = bad[j] ? WALK_BAD : WALK_GO;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- layout
   always_comb begin
      cfg_count_in   = cfg_count_ff;
      cfg_kinds_in   = cfg_kinds_ff;
      cfg_widths_in  = cfg_widths_ff;
      cfg_lengths_in = cfg_lengths_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_FIELD_COUNT:    cfg_count_in   = csr_wdata[2:0];
            CSR_FIELD_KINDS:    cfg_kinds_in   = csr_wdata[7:0];
            CSR_FIELD_WIDTHS:   cfg_widths_in  = csr_wdata[31:0];
            CSR_VECTOR_LENGTHS: cfg_lengths_in = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // fields past the register layout read kind integer, width zero: invalid
   for (genvar j = 0; j < MAX_FIELDS; j++) begin : g_field
      if (j < HW_FIELDS) begin : g_reg
         assign desc[j].kind  = kind_type'(cfg_kinds_ff[2*j +: 2]);
         assign desc[j].width = cfg_widths_ff[8*j +: 8];
         assign desc[j].count = cfg_lengths_ff[8*j +: 8];
      end else begin : g_none
         assign desc[j].kind  = KIND_INT;
         assign desc[j].width = 8'd0;
         assign desc[j].count = 8'd0;
      end
      // empty string or empty vector holds no bytes
      assign skip_vec[j] = (desc[j].kind == KIND_STR && desc[j].width == 8'd0) ||
                           (desc[j].kind == KIND_VEC && desc[j].count == 8'd0);
      assign bad_vec[j]  = (desc[j].kind == KIND_BAD) ||
                           (desc[j].kind != KIND_STR &&
                            desc[j].width != 8'd2 && desc[j].width != 8'd4);
   end

   assign used_4      = ({1'b0, cfg_count_ff} > MAX_FIELDS_4) ? MAX_FIELDS_4
                                                              : {1'b0, cfg_count_ff};
   assign used_fields = POS_W'(used_4);

   // ---------------------------------------------------------------- handshake
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign in_a_in     = (req_tvalid && req_tready) ? req_tdata[7:0]  : in_a_ff;
   assign in_b_in     = (req_tvalid && req_tready) ? req_tdata[15:8] : in_b_ff;

   // ---------------------------------------------------------------- walk and take
   always_comb begin
      // walk at the start of the step
      walk1   = walk_from(field_pos_ff, skip_vec, bad_vec, used_fields);
      moved1  = (walk1.pos != field_pos_ff);
      st_elem = moved1 ? '0 : element_pos_ff;
      st_bpos = moved1 ? '0 : byte_pos_ff;
      st_ga   = moved1 ? '0 : gather_a_ff;
      st_gb   = moved1 ? '0 : gather_b_ff;
      st_str  = moved1 ? 1'b0 : string_ended_ff;

      cur = desc[0];
      for (int j = 0; j < MAX_FIELDS; j++) begin
         if (walk1.pos == POS_W'(j)) cur = desc[j];
      end

      fold_a = fold_byte(in_a_ff);
      fold_b = fold_byte(in_b_ff);
      nb     = {1'b0, st_bpos} + 1'b1;
      insert = (st_bpos < BPOS_W'(4));

      // element so far with this byte dropped into its lane
      full_a = {8'h00, st_ga};
      full_b = {8'h00, st_gb};
      for (int b = 0; b < 4; b++) begin
         if (insert && st_bpos[1:0] == 2'(b)) begin
            full_a[8*b +: 8] = in_a_ff;
            full_b[8*b +: 8] = in_b_ff;
         end
      end
      int_lt = (cur.width == 8'd2) ? ($signed(full_a[15:0]) < $signed(full_b[15:0]))
                                   : ($signed(full_a) < $signed(full_b));
      int_eq = (cur.width == 8'd2) ? (full_a[15:0] == full_b[15:0]) : (full_a == full_b);

      str_width  = (cur.width > STR_CAP) ? STR_CAP : cur.width;
      elem_next  = {1'b0, st_elem} + 1'b1;
      elem_limit = (cur.kind == KIND_VEC) ? cur.count : 8'd1;

      t_decided  = decided_ff;
      t_order    = decided_order_ff;
      t_str      = st_str;
      t_elem     = st_elem;
      t_bpos     = BPOS_W'(nb);
      t_ga       = st_ga;
      t_gb       = st_gb;
      field_done = 1'b0;

      case (cur.kind)
         KIND_STR: begin
            if (!decided_ff && !st_str) begin
               if (fold_a != fold_b) begin
                  t_decided = 1'b1;
                  t_order   = (fold_a < fold_b) ? ORDER_LESS : ORDER_GREATER;
               end else if (in_a_ff == 8'h00) begin
                  t_str = 1'b1;   // both strings ended here
               end
            end
            field_done = (9'(nb) >= {1'b0, str_width});
         end
         default: begin
            t_ga = full_a[23:0];
            t_gb = full_b[23:0];
            if (9'(nb) >= {1'b0, cur.width}) begin
               if (!decided_ff && !int_eq) begin
                  t_decided = 1'b1;
                  t_order   = int_lt ? ORDER_LESS : ORDER_GREATER;
               end
               t_bpos     = '0;
               t_ga       = '0;
               t_gb       = '0;
               t_elem     = elem_next[7:0];
               field_done = (elem_next >= {1'b0, elem_limit});
            end
         end
      endcase

      pos_t = field_done ? walk1.pos + 1'b1 : walk1.pos;
      if (field_done) begin
         t_elem = '0;
         t_bpos = '0;
         t_ga   = '0;
         t_gb   = '0;
         t_str  = 1'b0;
      end

      // walk after the byte is consumed
      walk2  = walk_from(pos_t, skip_vec, bad_vec, used_fields);
      moved2 = (walk2.pos != pos_t);

      field_pos_in     = field_pos_ff;
      element_pos_in   = element_pos_ff;
      byte_pos_in      = byte_pos_ff;
      gather_a_in      = gather_a_ff;
      gather_b_in      = gather_b_ff;
      decided_in       = decided_ff;
      decided_order_in = decided_order_ff;
      string_ended_in  = string_ended_ff;
      res_fire         = 1'b0;
      rsp_order_in     = rsp_order_ff;
      rsp_status_in    = rsp_status_ff;

      if (advance) begin
         if (walk1.how != WALK_GO || walk2.how != WALK_GO) begin
            // key done: report and start the next pair
            res_fire = 1'b1;
            if (walk1.how != WALK_GO) begin
               rsp_order_in  = decided_ff ? decided_order_ff : ORDER_EQUAL;
               rsp_status_in = (walk1.how == WALK_BAD && !decided_ff) ? STATUS_BAD
                                                                      : STATUS_OK;
            end else begin
               rsp_order_in  = t_decided ? t_order : ORDER_EQUAL;
               rsp_status_in = (walk2.how == WALK_BAD && !t_decided) ? STATUS_BAD
                                                                     : STATUS_OK;
            end
            field_pos_in     = '0;
            element_pos_in   = '0;
            byte_pos_in      = '0;
            gather_a_in      = '0;
            gather_b_in      = '0;
            decided_in       = 1'b0;
            decided_order_in = ORDER_EQUAL;
            string_ended_in  = 1'b0;
         end else begin
            field_pos_in     = walk2.pos;
            element_pos_in   = moved2 ? '0 : t_elem;
            byte_pos_in      = moved2 ? '0 : t_bpos;
            gather_a_in      = moved2 ? '0 : t_ga;
            gather_b_in      = moved2 ? '0 : t_gb;
            string_ended_in  = moved2 ? 1'b0 : t_str;
            decided_in       = t_decided;
            decided_order_in = t_order;
         end
      end
   end

   assign rsp_valid_in = res_fire || (rsp_valid_ff && !rsp_tready);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_count_ff     <= CFG_COUNT_RESET;
         cfg_kinds_ff     <= CFG_KINDS_RESET;
         cfg_widths_ff    <= CFG_WIDTHS_RESET;
         cfg_lengths_ff   <= CFG_LENGTHS_RESET;
         in_valid_ff      <= 1'b0;
         field_pos_ff     <= '0;
         element_pos_ff   <= '0;
         byte_pos_ff      <= '0;
         gather_a_ff      <= '0;
         gather_b_ff      <= '0;
         decided_ff       <= 1'b0;
         decided_order_ff <= ORDER_EQUAL;
         string_ended_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_count_ff     <= cfg_count_in;
         cfg_kinds_ff     <= cfg_kinds_in;
         cfg_widths_ff    <= cfg_widths_in;
         cfg_lengths_ff   <= cfg_lengths_in;
         in_valid_ff      <= in_valid_in;
         field_pos_ff     <= field_pos_in;
         element_pos_ff   <= element_pos_in;
         byte_pos_ff      <= byte_pos_in;
         gather_a_ff      <= gather_a_in;
         gather_b_ff      <= gather_b_in;
         decided_ff       <= decided_in;
         decided_order_ff <= decided_order_in;
         string_ended_ff  <= string_ended_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_a_ff       <= in_a_in;
      in_b_ff       <= in_b_in;
      rsp_order_ff  <= rsp_order_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_order_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

### rtl/core/ckc_checker.sv
// Port-level checker for the composite key compare unit, bound to the top level.
`include "assert_macros.svh"

module ckc_checker
   import ckc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   // order is one of the three legal codes
   `CKC_ASSERT_IMP(a_order_legal, clock, reset, rsp_tvalid, rsp_tdata[1:0] == ORDER_LESS || rsp_tdata[1:0] == ORDER_EQUAL || rsp_tdata[1:0] == ORDER_GREATER)

   // an error only comes out of an undecided key
   `CKC_ASSERT_IMP(a_bad_is_equal, clock, reset, rsp_tvalid && rsp_tuser == STATUS_BAD, rsp_tdata[1:0] == ORDER_EQUAL)

   // with no result parked the input side is always open
   `CKC_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // stalled result holds
   `CKC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // reset empties the result register
   `CKC_ASSERT_NEXT_RAW(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind composite_key_compare_unit ckc_checker u_ckc_checker (.*);
